FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the reset is high.
`define APT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("apt assertion failed");

// Concurrent assertion that is also checked while the reset is high.
`define APT_ASSERT_NR(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("apt assertion failed");

`endif

FILE: rtl/apt_pkg.sv
package apt_pkg;

   localparam int FIELD_W    = 32;
   localparam int ANGLE_W    = 16;
   localparam int MAX_STAGES = 24;
   localparam int CX_W       = 34;
   localparam int CZ_W       = 33;
   localparam int FRAC_Q     = 30;
   localparam int PROD_W     = CX_W + FIELD_W;
   localparam int ROT_W      = PROD_W + 1 - FRAC_Q;
   localparam int SUM_W      = ROT_W + 1;

   typedef logic signed [FIELD_W-1:0] coord_type;
   typedef logic [ANGLE_W-1:0]        angle_type;
   typedef logic signed [CX_W-1:0]    cvec_type;
   typedef logic signed [CZ_W-1:0]    cang_type;
   typedef logic signed [ROT_W-1:0]   rot_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] quad;
      cvec_type   x;
      cvec_type   y;
      cang_type   z;
   } cordic_type;

   typedef struct packed {
      logic     valid;
      cvec_type c;
      cvec_type s;
   } trig_type;

   typedef struct packed {
      logic    valid;
      rot_type rot_x;
      rot_type rot_z;
   } rot_res_type;

   typedef struct packed {
      logic      anchored_mode;
      logic      height_from_query;
      logic      anchor_present;
      logic      height_present;
      coord_type offset_x;
      coord_type offset_y;
      coord_type offset_z;
      coord_type anchor_x;
      coord_type anchor_y;
      coord_type anchor_z;
      coord_type query_height;
   } rec_type;

   // Reciprocal CORDIC gain in Q4.30.
   localparam cvec_type CORDIC_GAIN = CX_W'(652032874);

   // Arctangent of 2^-i, with a full turn equal to 2^32.
   localparam logic [31:0] ATAN_TAB [MAX_STAGES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

endpackage

FILE: rtl/anchored_position_transform_core.sv
// Anchored position transform core.
// A request is taken at each rising clock edge where start is high and busy
// is low. It carries an offset triple, the anchored-mode and height flags,
// an optional anchor (heading and position) and an optional queried height.
// Each request gives exactly one response, marked by rsp_strobe for one cycle.
// The response passes the CORDIC entry register, the unrolled CORDIC stages
// (capped at 24), the trig, product, rotation and output registers.
// A new request may be issued in every cycle, so the sustained rate is one
// request per clock, and responses leave in request order.
// busy is high only while reset is high. A synchronous reset clears every
// valid bit in the pipeline, so requests in flight are dropped and no
// response appears until new requests arrive.
// The receiver cannot stall: each response is seen in its strobe cycle only.
// rsp_valid_res is low when a needed anchor or height was absent, and the
// positions then read as zero. Sums saturate to COORD_WIDTH bits (at most 32).
module anchored_position_transform_core #(
   parameter int CORDIC_STAGES = 16,
   parameter int COORD_WIDTH   = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_anchored_mode,
   input  logic               req_height_from_query,
   input  apt_pkg::coord_type req_offset_x,
   input  apt_pkg::coord_type req_offset_y,
   input  apt_pkg::coord_type req_offset_z,
   input  logic               req_anchor_present,
   input  apt_pkg::angle_type req_anchor_angle,
   input  apt_pkg::coord_type req_anchor_x,
   input  apt_pkg::coord_type req_anchor_y,
   input  apt_pkg::coord_type req_anchor_z,
   input  logic               req_height_present,
   input  apt_pkg::coord_type req_query_height,
   output logic               rsp_strobe,
   output logic               rsp_valid_res,
   output apt_pkg::coord_type rsp_pos_x,
   output apt_pkg::coord_type rsp_pos_y,
   output apt_pkg::coord_type rsp_pos_z
);
   import apt_pkg::*;

   localparam int NS        = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
   localparam int SAT_W     = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;
   localparam int REC_DEPTH = NS + 4;
   localparam int TAP_ROT   = NS + 1;
   localparam int TAP_OUT   = NS + 3;
   localparam logic signed [SUM_W-1:0] SAT_HI =
      SUM_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

   function automatic coord_type saturate(input logic signed [SUM_W-1:0] v);
      coord_type res;
      priority if (v > SAT_HI) begin
         res = coord_type'(SAT_HI);
      end else if (v < SAT_LO) begin
         res = coord_type'(SAT_LO);
      end else begin
         res = coord_type'(v);
      end
      return res;
   endfunction

   logic                     accept;
   rec_type                  rec_in;
   rec_type                  rec_ff [REC_DEPTH];
   rec_type                  rec_out;
   trig_type                 trig;
   rot_res_type              rot;
   logic signed [SUM_W-1:0]  sum_x;
   logic signed [SUM_W-1:0]  sum_y;
   logic signed [SUM_W-1:0]  sum_z;
   logic                     res_ok;
   logic                     strobe_ff;
   logic                     valid_res_ff;
   logic                     valid_res_in;
   coord_type                pos_x_ff;
   coord_type                pos_y_ff;
   coord_type                pos_z_ff;
   coord_type                pos_x_in;
   coord_type                pos_y_in;
   coord_type                pos_z_in;

   assign busy   = reset;
   assign accept = start & ~reset;

   always_comb begin
      rec_in.anchored_mode     = req_anchored_mode;
      rec_in.height_from_query = req_height_from_query;
      rec_in.anchor_present    = req_anchor_present;
      rec_in.height_present    = req_height_present;
      rec_in.offset_x          = req_offset_x;
      rec_in.offset_y          = req_offset_y;
      rec_in.offset_z          = req_offset_z;
      rec_in.anchor_x          = req_anchor_x;
      rec_in.anchor_y          = req_anchor_y;
      rec_in.anchor_z          = req_anchor_z;
      rec_in.query_height      = req_query_height;
   end

   always_ff @(posedge clock) begin
      rec_ff[0] <= rec_in;
      for (int k = 1; k < REC_DEPTH; k++) begin
         rec_ff[k] <= rec_ff[k-1];
      end
   end

   apt_cordic #(.STAGES(NS)) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .angle    (req_anchor_angle),
      .trig     (trig)
   );

   apt_rotate u_rotate (
      .clock    (clock),
      .reset    (reset),
      .trig     (trig),
      .offset_x (rec_ff[TAP_ROT].offset_x),
      .offset_z (rec_ff[TAP_ROT].offset_z),
      .rot      (rot)
   );

   assign rec_out = rec_ff[TAP_OUT];

   always_comb begin
      if (rec_out.anchored_mode) begin
         sum_x = SUM_W'(rec_out.anchor_x) + SUM_W'(rot.rot_x);
         sum_z = SUM_W'(rec_out.anchor_z) + SUM_W'(rot.rot_z);
      end else begin
         sum_x = SUM_W'(rec_out.offset_x);
         sum_z = SUM_W'(rec_out.offset_z);
      end
      priority if (rec_out.height_from_query) begin
         sum_y = SUM_W'(rec_out.query_height) + SUM_W'(rec_out.offset_y);
      end else if (rec_out.anchored_mode) begin
         sum_y = SUM_W'(rec_out.anchor_y) + SUM_W'(rec_out.offset_y);
      end else begin
         sum_y = SUM_W'(rec_out.offset_y);
      end
      res_ok = !(rec_out.anchored_mode && !rec_out.anchor_present) &&
               !(rec_out.height_from_query && !rec_out.height_present);
      valid_res_in = res_ok;
      pos_x_in     = res_ok ? saturate(sum_x) : '0;
      pos_y_in     = res_ok ? saturate(sum_y) : '0;
      pos_z_in     = res_ok ? saturate(sum_z) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= rot.valid;
      end
      valid_res_ff <= valid_res_in;
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      pos_z_ff     <= pos_z_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_valid_res = valid_res_ff;
   assign rsp_pos_x     = pos_x_ff;
   assign rsp_pos_y     = pos_y_ff;
   assign rsp_pos_z     = pos_z_ff;

endmodule

FILE: rtl/apt_cstage.sv
module apt_cstage #(
   parameter int SHIFT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  apt_pkg::cordic_type prev_stage,
   output apt_pkg::cordic_type next_stage
);
   import apt_pkg::*;

   cordic_type stage_ff;
   cordic_type stage_in;
   cvec_type   x_old;
   cvec_type   y_old;
   cvec_type   dx;
   cvec_type   dy;
   cang_type   z_old;
   cang_type   z_step;

   always_comb begin
      x_old  = prev_stage.x;
      y_old  = prev_stage.y;
      z_old  = prev_stage.z;
      dx     = y_old >>> SHIFT;
      dy     = x_old >>> SHIFT;
      z_step = cang_type'(ATAN_TAB[SHIFT]);
      stage_in.valid = prev_stage.valid;
      stage_in.quad  = prev_stage.quad;
      if (!z_old[CZ_W-1]) begin
         stage_in.x = x_old - dx;
         stage_in.y = y_old + dy;
         stage_in.z = z_old - z_step;
      end else begin
         stage_in.x = x_old + dx;
         stage_in.y = y_old - dy;
         stage_in.z = z_old + z_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign next_stage = stage_ff;

endmodule

FILE: rtl/apt_cordic.sv
module apt_cordic #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  apt_pkg::angle_type angle,
   output apt_pkg::trig_type  trig
);
   import apt_pkg::*;

   angle_type  angle_sum;
   angle_type  resid;
   logic [1:0] quad;
   cordic_type entry_ff;
   cordic_type entry_in;
   cordic_type chain [STAGES+1];
   cordic_type last;
   trig_type   trig_ff;
   trig_type   trig_in;

   always_comb begin
      angle_sum      = angle + 16'h2000;
      quad           = angle_sum[ANGLE_W-1:ANGLE_W-2];
      resid          = angle - {quad, 14'h0000};
      entry_in.valid = in_valid;
      entry_in.quad  = quad;
      entry_in.x     = CORDIC_GAIN;
      entry_in.y     = '0;
      entry_in.z     = cang_type'($signed({resid, 16'h0000}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign chain[0] = entry_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      apt_cstage #(.SHIFT(i)) u_stage (
         .clock      (clock),
         .reset      (reset),
         .prev_stage (chain[i]),
         .next_stage (chain[i+1])
      );
   end

   assign last = chain[STAGES];

   always_comb begin
      trig_in.valid = last.valid;
      unique case (last.quad)
         2'd0: begin
            trig_in.c = last.x;
            trig_in.s = last.y;
         end
         2'd1: begin
            trig_in.c = -last.y;
            trig_in.s = last.x;
         end
         2'd2: begin
            trig_in.c = -last.x;
            trig_in.s = -last.y;
         end
         default: begin
            trig_in.c = last.y;
            trig_in.s = -last.x;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff <= '0;
      end else begin
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

FILE: rtl/apt_rotate.sv
module apt_rotate (
   input  logic                 clock,
   input  logic                 reset,
   input  apt_pkg::trig_type    trig,
   input  apt_pkg::coord_type   offset_x,
   input  apt_pkg::coord_type   offset_z,
   output apt_pkg::rot_res_type rot
);
   import apt_pkg::*;

   localparam logic signed [PROD_W:0] ROUND_BIAS = (PROD_W+1)'(1) << (FRAC_Q - 1);

   cvec_type                  cos_v;
   cvec_type                  sin_v;
   logic signed [PROD_W-1:0]  cx_in;
   logic signed [PROD_W-1:0]  sz_in;
   logic signed [PROD_W-1:0]  cz_in;
   logic signed [PROD_W-1:0]  sx_in;
   logic signed [PROD_W-1:0]  cx_ff;
   logic signed [PROD_W-1:0]  sz_ff;
   logic signed [PROD_W-1:0]  cz_ff;
   logic signed [PROD_W-1:0]  sx_ff;
   logic                      prod_valid_ff;
   logic signed [PROD_W:0]    sum_x;
   logic signed [PROD_W:0]    sum_z;
   rot_res_type               rot_in;
   rot_res_type               rot_ff;

   always_comb begin
      cos_v = trig.c;
      sin_v = trig.s;
      cx_in = cos_v * offset_x;
      sz_in = sin_v * offset_z;
      cz_in = cos_v * offset_z;
      sx_in = sin_v * offset_x;
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      sz_ff <= sz_in;
      cz_ff <= cz_in;
      sx_ff <= sx_in;
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= trig.valid;
      end
   end

   always_comb begin
      sum_x = (PROD_W+1)'(cx_ff) + (PROD_W+1)'(sz_ff) + ROUND_BIAS;
      sum_z = (PROD_W+1)'(cz_ff) - (PROD_W+1)'(sx_ff) + ROUND_BIAS;
      rot_in.valid = prod_valid_ff;
      rot_in.rot_x = rot_type'(sum_x >>> FRAC_Q);
      rot_in.rot_z = rot_type'(sum_z >>> FRAC_Q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff <= '0;
      end else begin
         rot_ff <= rot_in;
      end
   end

   assign rot = rot_ff;

endmodule

FILE: rtl/apt_checker.sv
`include "assert_macros.svh"

module apt_checker #(
   parameter int CORDIC_STAGES = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic               rsp_valid_res,
   input apt_pkg::coord_type rsp_pos_x,
   input apt_pkg::coord_type rsp_pos_y,
   input apt_pkg::coord_type rsp_pos_z
);
   import apt_pkg::*;

   localparam int NS      = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
   localparam int LATENCY = NS + 5;

   // Every request gives a response after the fixed pipeline latency.
   `APT_ASSERT(a_rsp_follows_req, clock, reset, (start && !busy) |-> ##LATENCY rsp_strobe)
   // No response appears without a request that latency earlier.
   `APT_ASSERT(a_rsp_has_req, clock, reset, rsp_strobe |-> $past(start && !busy, LATENCY))
   // A failed resolution reports a zero position.
   `APT_ASSERT(a_invalid_zero, clock, reset, (rsp_strobe && !rsp_valid_res) |-> (rsp_pos_x == 0 && rsp_pos_y == 0 && rsp_pos_z == 0))
   // Reset flushes the pipeline.
   `APT_ASSERT_NR(a_reset_flush, clock, $past(reset) |-> !rsp_strobe)

endmodule

bind anchored_position_transform_core apt_checker #(
   .CORDIC_STAGES (CORDIC_STAGES)
) u_apt_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_valid_res (rsp_valid_res),
   .rsp_pos_x     (rsp_pos_x),
   .rsp_pos_y     (rsp_pos_y),
   .rsp_pos_z     (rsp_pos_z)
);

FILE: tb/tb_anchored_position_transform_core.sv
module tb_anchored_position_transform_core;
   timeunit 1ns;
   timeprecision 1ps;

   import apt_pkg::*;

   localparam int      STAGES       = 16;
   localparam int      WIDTH        = 32;
   localparam int      RANDOM_COUNT = 600;
   localparam int      CYCLE_LIMIT  = 200000;
   localparam longint  GAIN_Q30     = 64'sd652032874;
   localparam longint  HALF_Q30     = 64'sd536870912;
   localparam coord_type ONE        = 32'sh0001_0000;
   localparam coord_type COORD_MAX  = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN  = 32'sh8000_0000;

   localparam longint ARCTAN_STEP [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   typedef struct {
      logic      anchored_mode;
      logic      height_from_query;
      coord_type offset_x;
      coord_type offset_y;
      coord_type offset_z;
      logic      anchor_present;
      angle_type anchor_angle;
      coord_type anchor_x;
      coord_type anchor_y;
      coord_type anchor_z;
      logic      height_present;
      coord_type query_height;
   } request_type;

   typedef struct {
      logic      valid;
      coord_type x;
      coord_type y;
      coord_type z;
   } position_type;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   logic      req_anchored_mode;
   logic      req_height_from_query;
   coord_type req_offset_x;
   coord_type req_offset_y;
   coord_type req_offset_z;
   logic      req_anchor_present;
   angle_type req_anchor_angle;
   coord_type req_anchor_x;
   coord_type req_anchor_y;
   coord_type req_anchor_z;
   logic      req_height_present;
   coord_type req_query_height;
   logic      rsp_strobe;
   logic      rsp_valid_res;
   coord_type rsp_pos_x;
   coord_type rsp_pos_y;
   coord_type rsp_pos_z;

   position_type pending_positions [$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           burst_left  = 0;

   anchored_position_transform_core #(
      .CORDIC_STAGES(STAGES),
      .COORD_WIDTH  (WIDTH)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_anchored_mode    (req_anchored_mode),
      .req_height_from_query(req_height_from_query),
      .req_offset_x         (req_offset_x),
      .req_offset_y         (req_offset_y),
      .req_offset_z         (req_offset_z),
      .req_anchor_present   (req_anchor_present),
      .req_anchor_angle     (req_anchor_angle),
      .req_anchor_x         (req_anchor_x),
      .req_anchor_y         (req_anchor_y),
      .req_anchor_z         (req_anchor_z),
      .req_height_present   (req_height_present),
      .req_query_height     (req_query_height),
      .rsp_strobe           (rsp_strobe),
      .rsp_valid_res        (rsp_valid_res),
      .rsp_pos_x            (rsp_pos_x),
      .rsp_pos_y            (rsp_pos_y),
      .rsp_pos_z            (rsp_pos_z)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint saturate(input longint v);
      int     w;
      longint hi;
      longint lo;
      w = (WIDTH > 32) ? 32 : ((WIDTH < 2) ? 2 : WIDTH);
      hi = (64'sd1 <<< (w - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic position_type resolve_position(input request_type rq);
      position_type res;
      logic [15:0]  shifted;
      logic [15:0]  resid;
      logic [1:0]   quad;
      longint       x, y, z, dx, dy, c, s;
      longint       ox, oy, oz, px, py, pz;
      int           last;
      res = '{valid: 1'b0, x: '0, y: '0, z: '0};
      ox = longint'(rq.offset_x);
      oy = longint'(rq.offset_y);
      oz = longint'(rq.offset_z);
      px = ox;
      py = oy;
      pz = oz;
      if (rq.anchored_mode) begin
         if (!rq.anchor_present) return res;
         shifted = rq.anchor_angle + 16'h2000;
         quad = shifted[15:14];
         resid = rq.anchor_angle - {quad, 14'd0};
         x = GAIN_Q30;
         y = 64'sd0;
         z = longint'($signed(resid)) * 64'sd65536;
         last = (STAGES > 24) ? 24 : STAGES;
         for (int i = 0; i < last; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - ARCTAN_STEP[i];
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + ARCTAN_STEP[i];
            end
         end
         case (quad)
            2'd0: begin
               c = x;
               s = y;
            end
            2'd1: begin
               c = -y;
               s = x;
            end
            2'd2: begin
               c = -x;
               s = -y;
            end
            default: begin
               c = y;
               s = -x;
            end
         endcase
         px = saturate(longint'(rq.anchor_x) + ((c * ox + s * oz + HALF_Q30) >>> 30));
         py = saturate(longint'(rq.anchor_y) + oy);
         pz = saturate(longint'(rq.anchor_z) + ((c * oz - s * ox + HALF_Q30) >>> 30));
      end
      if (rq.height_from_query) begin
         if (!rq.height_present) return res;
         py = saturate(longint'(rq.query_height) + oy);
      end
      res.valid = 1'b1;
      res.x = coord_type'(saturate(px));
      res.y = coord_type'(saturate(py));
      res.z = coord_type'(saturate(pz));
      return res;
   endfunction

   function automatic request_type make_request(
      input logic anchored, input logic from_query,
      input coord_type ox, input coord_type oy, input coord_type oz,
      input logic anchor_ok, input angle_type heading,
      input coord_type ax, input coord_type ay, input coord_type az,
      input logic height_ok, input coord_type height);
      request_type rq;
      rq.anchored_mode     = anchored;
      rq.height_from_query = from_query;
      rq.offset_x          = ox;
      rq.offset_y          = oy;
      rq.offset_z          = oz;
      rq.anchor_present    = anchor_ok;
      rq.anchor_angle      = heading;
      rq.anchor_x          = ax;
      rq.anchor_y          = ay;
      rq.anchor_z          = az;
      rq.height_present    = height_ok;
      rq.query_height      = height;
      return rq;
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 11))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2, 3, 4: return coord_type'($urandom);
         default: return coord_type'(int'($urandom_range(0, 2097152)) - 1048576);
      endcase
   endfunction

   function automatic angle_type pick_heading();
      if ($urandom_range(0, 3) == 0)
         return angle_type'($urandom_range(0, 3) * 16384 + 8192 + $urandom_range(0, 4) - 2);
      return angle_type'($urandom);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s at cycle %0d: got %h, expected %h",
               what, cycle_count, got, want);
      error_count++;
   endtask

   task automatic send_request(input request_type rq);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      req_anchored_mode     <= rq.anchored_mode;
      req_height_from_query <= rq.height_from_query;
      req_offset_x          <= rq.offset_x;
      req_offset_y          <= rq.offset_y;
      req_offset_z          <= rq.offset_z;
      req_anchor_present    <= rq.anchor_present;
      req_anchor_angle      <= rq.anchor_angle;
      req_anchor_x          <= rq.anchor_x;
      req_anchor_y          <= rq.anchor_y;
      req_anchor_z          <= rq.anchor_z;
      req_height_present    <= rq.height_present;
      req_query_height      <= rq.query_height;
      start                 <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      burst_left--;
   endtask

   always @(posedge clock) begin
      position_type want;
      request_type  seen;
      cycle_count++;
      if (!reset && start && !busy) begin
         seen = make_request(req_anchored_mode, req_height_from_query, req_offset_x,
                             req_offset_y, req_offset_z, req_anchor_present,
                             req_anchor_angle, req_anchor_x, req_anchor_y, req_anchor_z,
                             req_height_present, req_query_height);
         pending_positions.push_back(resolve_position(seen));
      end
      if (!reset && rsp_strobe) begin
         if (pending_positions.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_valid_res), 32'h0);
         end else begin
            want = pending_positions.pop_front();
            if (rsp_valid_res !== want.valid)
               report_mismatch("valid_res", 32'(rsp_valid_res), 32'(want.valid));
            if (rsp_pos_x !== want.x) report_mismatch("pos_x", rsp_pos_x, want.x);
            if (rsp_pos_y !== want.y) report_mismatch("pos_y", rsp_pos_y, want.y);
            if (rsp_pos_z !== want.z) report_mismatch("pos_z", rsp_pos_z, want.z);
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic test_pass_through();
      send_request(make_request(1'b0, 1'b0, '0, '0, '0, 1'b0, '0, '0, '0, '0, 1'b0, '0));
      send_request(make_request(1'b0, 1'b0, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 16'hFFFF,
                                COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, COORD_MIN));
      send_request(make_request(1'b0, 1'b0, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 16'h1234,
                                32'sh1234_5678, COORD_MIN, 32'shDEAD_BEEF, 1'b1, COORD_MAX));
   endtask

   task automatic test_missing_inputs();
      send_request(make_request(1'b1, 1'b0, ONE, ONE, ONE, 1'b0, 16'h4000, ONE, ONE, ONE,
                                1'b1, ONE));
      send_request(make_request(1'b0, 1'b1, ONE, ONE, ONE, 1'b1, 16'h4000, ONE, ONE, ONE,
                                1'b0, ONE));
      send_request(make_request(1'b1, 1'b1, ONE, ONE, ONE, 1'b0, 16'h4000, ONE, ONE, ONE,
                                1'b0, ONE));
      send_request(make_request(1'b1, 1'b1, ONE, ONE, ONE, 1'b1, 16'h4000, ONE, ONE, ONE,
                                1'b0, ONE));
      send_request(make_request(1'b1, 1'b1, ONE, -ONE, ONE, 1'b1, 16'h2A00, ONE, ONE, ONE,
                                1'b1, 32'sh0005_8000));
   endtask

   task automatic test_heading_quadrants();
      angle_type headings [10] = '{16'h0000, 16'h1FFF, 16'h2000, 16'h4000, 16'h6000,
                                   16'h8000, 16'hA000, 16'hC000, 16'hE000, 16'hFFFF};
      foreach (headings[i])
         send_request(make_request(1'b1, 1'b0, ONE, 32'sh0002_0000, -32'sh0003_0000, 1'b1,
                                   headings[i], 32'sh000A_0000, -ONE, 32'sh0000_8000,
                                   1'b0, '0));
   endtask

   task automatic test_saturation();
      send_request(make_request(1'b1, 1'b0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 16'h0000,
                                COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, '0));
      send_request(make_request(1'b1, 1'b0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 16'h0000,
                                COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, '0));
      send_request(make_request(1'b1, 1'b0, COORD_MAX, '0, COORD_MAX, 1'b1, 16'h2000,
                                '0, '0, '0, 1'b0, '0));
      send_request(make_request(1'b0, 1'b1, '0, COORD_MAX, '0, 1'b0, '0, '0, '0, '0,
                                1'b1, COORD_MAX));
      send_request(make_request(1'b1, 1'b1, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1, 16'hA000,
                                COORD_MAX, COORD_MAX, COORD_MIN, 1'b1, COORD_MIN));
   endtask

   task automatic test_random_records();
      request_type rq;
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         rq = make_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_coord(),
                           pick_coord(), pick_coord(), 1'($urandom_range(0, 1)),
                           pick_heading(), pick_coord(), pick_coord(), pick_coord(),
                           1'($urandom_range(0, 1)), pick_coord());
         // Most records carry whatever their flags ask for, so that they resolve.
         if ($urandom_range(0, 3) != 0) begin
            if (rq.anchored_mode) rq.anchor_present = 1'b1;
            if (rq.height_from_query) rq.height_present = 1'b1;
         end
         send_request(rq);
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      start                 <= 1'b0;
      req_anchored_mode     <= 1'b0;
      req_height_from_query <= 1'b0;
      req_offset_x          <= '0;
      req_offset_y          <= '0;
      req_offset_z          <= '0;
      req_anchor_present    <= 1'b0;
      req_anchor_angle      <= '0;
      req_anchor_x          <= '0;
      req_anchor_y          <= '0;
      req_anchor_z          <= '0;
      req_height_present    <= 1'b0;
      req_query_height      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_pass_through();
      test_missing_inputs();
      test_heading_quadrants();
      test_saturation();
      test_random_records();

      start <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (STAGES + 10) @(posedge clock);

      if (error_count == 0 && pending_positions.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
